// File: rtl/core/lpi_pkg.sv
package lpi_pkg;

   localparam int MAX_STEPS  = 63;
   localparam int FRAC_BITS  = 16;
   localparam int COORD_W    = 32;
   localparam int STEPS_W    = 6;
   localparam int DIFF_W     = COORD_W + 1;
   localparam int REM_W      = STEPS_W + 1;
   localparam int DIV_BITS   = DIFF_W;
   localparam int CNT_W      = $clog2(DIV_BITS);
   localparam int REQ_DATA_W = ((6 * COORD_W + STEPS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((3 * COORD_W + STEPS_W + 7) / 8) * 8;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [STEPS_W-1:0]        steps_type;

   typedef struct packed {
      logic load;
      logic step;
      logic finish;
      logic advance;
   } lane_ctrl_type;

   // negation that maps the most negative value to the most positive
   function automatic coord_type neg_sat(input coord_type v);
      coord_type r;
      if (v == {1'b1, {(COORD_W-1){1'b0}}}) begin
         r = {1'b0, {(COORD_W-1){1'b1}}};
      end else begin
         r = -v;
      end
      return r;
   endfunction

endpackage

// File: rtl/core/lpi_axis_lane.sv
module lpi_axis_lane (
   input  logic                  clock,
   input  lpi_pkg::lane_ctrl_type ctrl,
   input  lpi_pkg::coord_type    start_val,
   input  lpi_pkg::coord_type    end_val,
   input  lpi_pkg::steps_type    divisor,
   output lpi_pkg::coord_type    point_val,
   output lpi_pkg::coord_type    end_out
);

   logic [lpi_pkg::DIFF_W-1:0] quot_ff, quot_in;
   logic [lpi_pkg::REM_W-1:0]  rem_ff, rem_in;
   lpi_pkg::steps_type         div_ff, div_in;
   logic                       neg_ff, neg_in;
   lpi_pkg::coord_type         slope_ff, slope_in;
   lpi_pkg::coord_type         point_ff, point_in;
   lpi_pkg::coord_type         end_ff, end_in;

   logic signed [lpi_pkg::DIFF_W-1:0] diff;
   logic [lpi_pkg::REM_W-1:0]         rem_shift;
   logic                              rem_ge;
   logic [lpi_pkg::DIFF_W-1:0]        quot_signed;

   always_comb begin
      diff      = {end_val[lpi_pkg::COORD_W-1], end_val}
                - {start_val[lpi_pkg::COORD_W-1], start_val};
      rem_shift = {rem_ff[lpi_pkg::REM_W-2:0], quot_ff[lpi_pkg::DIFF_W-1]};
      rem_ge    = rem_shift >= {1'b0, div_ff};
      quot_signed = neg_ff ? -quot_ff : quot_ff;

      quot_in  = quot_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      neg_in   = neg_ff;
      slope_in = slope_ff;
      point_in = point_ff;
      end_in   = end_ff;

      if (ctrl.load) begin
         // divide magnitudes, restore sign afterwards: truncates toward zero
         neg_in   = diff[lpi_pkg::DIFF_W-1];
         quot_in  = diff[lpi_pkg::DIFF_W-1] ? -diff : diff;
         rem_in   = '0;
         div_in   = divisor;
         point_in = start_val;
         end_in   = end_val;
      end else if (ctrl.step) begin
         rem_in  = rem_ge ? (rem_shift - {1'b0, div_ff}) : rem_shift;
         quot_in = {quot_ff[lpi_pkg::DIFF_W-2:0], rem_ge};
      end else if (ctrl.finish) begin
         slope_in = quot_signed[lpi_pkg::COORD_W-1:0];
      end else if (ctrl.advance) begin
         point_in = point_ff + slope_ff;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff  <= quot_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
      neg_ff   <= neg_in;
      slope_ff <= slope_in;
      point_ff <= point_in;
      end_ff   <= end_in;
   end

   assign point_val = point_ff;
   assign end_out   = end_ff;

endmodule

// File: rtl/core/line_point_interpolator.sv
// an item with zero steps skips the divider and emits its end vertex alone
// otherwise each axis lane runs a one-bit-a-cycle divider, then the ST_FIN state forms the slope
// points then leave at one per cycle while rsp_tready stays high
// a new item is accepted only after the last point of the previous one is handed over
// synchronous active-high reset clears the control state and rsp_tvalid
// datapath registers are not reset
module line_point_interpolator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, steps, zero pad
   input  logic [lpi_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // point_x, point_y, point_z, point_index, zero pad
   output logic [lpi_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                             rsp_tlast
);

   localparam int CW = lpi_pkg::COORD_W;
   localparam int SW = lpi_pkg::STEPS_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_FIN,
      ST_EMIT
   } state_type;

   state_type               state_ff;
   logic [lpi_pkg::CNT_W-1:0] cnt_ff;
   lpi_pkg::steps_type      n_ff;
   lpi_pkg::steps_type      idx_ff;
   logic                    drain_ff;
   logic                    rsp_valid_ff;
   lpi_pkg::coord_type      out_x_ff, out_y_ff, out_z_ff;
   lpi_pkg::steps_type      out_idx_ff;
   logic                    out_last_ff;

   lpi_pkg::coord_type      in_start [3];
   lpi_pkg::coord_type      in_end [3];
   lpi_pkg::coord_type      lane_point [3];
   lpi_pkg::coord_type      lane_end [3];
   lpi_pkg::coord_type      merged [3];
   lpi_pkg::steps_type      in_steps, n_sat;
   lpi_pkg::lane_ctrl_type  ctrl;
   logic                    req_accept, rsp_accept, emit_load, at_end;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_accept = rsp_valid_ff && rsp_tready;
   assign emit_load  = (state_ff == ST_EMIT) && !drain_ff && (!rsp_valid_ff || rsp_tready);
   assign at_end     = (idx_ff == n_ff);

   always_comb begin
      in_start[0] = req_tdata[CW-1:0];
      in_start[1] = req_tdata[2*CW-1:CW];
      in_start[2] = lpi_pkg::neg_sat(req_tdata[3*CW-1:2*CW]);
      in_end[0]   = req_tdata[4*CW-1:3*CW];
      in_end[1]   = req_tdata[5*CW-1:4*CW];
      in_end[2]   = lpi_pkg::neg_sat(req_tdata[6*CW-1:5*CW]);
      in_steps    = req_tdata[6*CW+SW-1:6*CW];
      n_sat       = (in_steps > SW'(lpi_pkg::MAX_STEPS)) ? SW'(lpi_pkg::MAX_STEPS) : in_steps;
   end

   always_comb begin
      ctrl.load    = req_accept;
      ctrl.step    = (state_ff == ST_DIV);
      ctrl.finish  = (state_ff == ST_FIN);
      ctrl.advance = emit_load;
   end

   for (genvar a = 0; a < 3; a++) begin : g_lane
      lpi_axis_lane u_lane (
         .clock     (clock),
         .ctrl      (ctrl),
         .start_val (in_start[a]),
         .end_val   (in_end[a]),
         .divisor   (n_sat),
         .point_val (lane_point[a]),
         .end_out   (lane_end[a])
      );
      // merge: final point is the end vertex exactly
      assign merged[a] = at_end ? lane_end[a] : lane_point[a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         drain_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_accept && !emit_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_accept) begin
                  n_ff     <= n_sat;
                  idx_ff   <= '0;
                  cnt_ff   <= '0;
                  drain_ff <= 1'b0;
                  state_ff <= (n_sat == '0) ? ST_EMIT : ST_DIV;
               end
            end
            ST_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == lpi_pkg::CNT_W'(lpi_pkg::DIV_BITS - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (emit_load) begin
                  rsp_valid_ff <= 1'b1;
                  out_x_ff     <= merged[0];
                  out_y_ff     <= merged[1];
                  out_z_ff     <= merged[2];
                  out_idx_ff   <= idx_ff;
                  out_last_ff  <= at_end;
                  idx_ff       <= idx_ff + 1'b1;
                  if (at_end) begin
                     drain_ff <= 1'b1;
                  end
               end
               // last point handed over: ready for the next item
               if (drain_ff && rsp_accept) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(lpi_pkg::RSP_DATA_W - 3*CW - SW){1'b0}},
                        out_idx_ff, out_z_ff, out_y_ff, out_x_ff};

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_valid_ff)
      else $error("input accepted while a point is still pending");

   a_valid_only_when_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_EMIT))
      else $error("point valid outside emission");

   a_index_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !drain_ff) |-> (idx_ff <= n_ff))
      else $error("point index ran past step count");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && out_last_ff) |=> (state_ff == ST_IDLE))
      else $error("run did not end after last point");

endmodule

// File: verif/line_point_checker.sv
`timescale 1ns / 100ps

module line_point_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // start_x, start_y, start_z, end_x, end_y, end_z, steps, zero pad
   input  logic [lpi_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // point_x, point_y, point_z, point_index, zero pad
   input  logic [lpi_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   output int                             errors,
   output int                             pending
);

   localparam int PRINT_LIMIT = 50;

   typedef struct packed {
      lpi_pkg::coord_type x;
      lpi_pkg::coord_type y;
      lpi_pkg::coord_type z;
      lpi_pkg::steps_type pos;
      logic               last;
   } point_type;

   point_type expected_points[$];

   initial begin
      errors  = 0;
      pending = 0;
   end

   task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
      if (errors < PRINT_LIMIT) begin
         $display("%0t %s: expected %h, got %h", $time, what, want, got);
      end
      errors++;
   endtask

   function automatic longint negate_clamped(input longint v);
      longint r;
      if (v == -longint'(64'sd2147483648)) begin
         r = 64'sd2147483647;
      end else begin
         r = -v;
      end
      return r;
   endfunction

   task automatic push_point(input longint v[3], input int pos, input logic last);
      point_type p;
      p.x    = v[0][lpi_pkg::COORD_W-1:0];
      p.y    = v[1][lpi_pkg::COORD_W-1:0];
      p.z    = v[2][lpi_pkg::COORD_W-1:0];
      p.pos  = pos[lpi_pkg::STEPS_W-1:0];
      p.last = last;
      expected_points.push_back(p);
   endtask

   task automatic predict_points(input logic [lpi_pkg::REQ_DATA_W-1:0] d);
      lpi_pkg::coord_type c;
      longint             from_v[3];
      longint             to_v[3];
      longint             slope[3];
      longint             acc[3];
      int                 n;
      for (int a = 0; a < 3; a++) begin
         c = d[a*lpi_pkg::COORD_W +: lpi_pkg::COORD_W];
         from_v[a] = c;
         c = d[(a+3)*lpi_pkg::COORD_W +: lpi_pkg::COORD_W];
         to_v[a] = c;
      end
      // z is negated on entry
      from_v[2] = negate_clamped(from_v[2]);
      to_v[2]   = negate_clamped(to_v[2]);
      n = int'(d[6*lpi_pkg::COORD_W +: lpi_pkg::STEPS_W]);
      if (n > lpi_pkg::MAX_STEPS) begin
         n = lpi_pkg::MAX_STEPS;
      end
      if (n == 0) begin
         push_point(to_v, 0, 1'b1);
      end else begin
         for (int a = 0; a < 3; a++) begin
            slope[a] = (to_v[a] - from_v[a]) / longint'(n);
            acc[a]   = from_v[a];
         end
         for (int i = 0; i < n; i++) begin
            push_point(acc, i, 1'b0);
            for (int a = 0; a < 3; a++) begin
               acc[a] += slope[a];
            end
         end
         push_point(to_v, n, 1'b1);
      end
   endtask

   always @(posedge clock) begin
      point_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_points(req_tdata);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_points.size() == 0) begin
               report("point with none outstanding", '0, rsp_tdata[63:0]);
            end else begin
               want = expected_points.pop_front();
               if (rsp_tdata[0 +: lpi_pkg::COORD_W] !== want.x) begin
                  report("point_x", want.x, rsp_tdata[0 +: lpi_pkg::COORD_W]);
               end
               if (rsp_tdata[lpi_pkg::COORD_W +: lpi_pkg::COORD_W] !== want.y) begin
                  report("point_y", want.y, rsp_tdata[lpi_pkg::COORD_W +: lpi_pkg::COORD_W]);
               end
               if (rsp_tdata[2*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] !== want.z) begin
                  report("point_z", want.z,
                         rsp_tdata[2*lpi_pkg::COORD_W +: lpi_pkg::COORD_W]);
               end
               if (rsp_tdata[3*lpi_pkg::COORD_W +: lpi_pkg::STEPS_W] !== want.pos) begin
                  report("point_index", want.pos,
                         rsp_tdata[3*lpi_pkg::COORD_W +: lpi_pkg::STEPS_W]);
               end
               if (rsp_tlast !== want.last) begin
                  report("last", want.last, rsp_tlast);
               end
            end
         end
      end
      pending <= expected_points.size();
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int RESET_CYCLES = 4;
   localparam int RANDOM_ITEMS = 205;
   localparam int IDLE_LIMIT   = 4000;
   localparam int DRAIN_CYCLES = 48;
   localparam int HOLD_AT      = 60;
   localparam int HOLD_CYCLES  = 300;

   localparam lpi_pkg::coord_type C_MIN = 32'sh8000_0000;
   localparam lpi_pkg::coord_type C_MAX = 32'sh7fff_ffff;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic [lpi_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tready = 1'b0;
   logic                           req_tready;
   logic                           rsp_tvalid;
   logic [lpi_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;

   int errors;
   int pending;
   int idle_cycles = 0;
   bit send_calm   = 1'b0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   line_point_interpolator i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   line_point_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending)
   );

   function automatic int gap_len(input bit calm);
      int r;
      int g;
      r = $urandom_range(0, 99);
      if (calm || r < 55) begin
         g = 0;
      end else if (r < 88) begin
         g = $urandom_range(1, 3);
      end else begin
         g = $urandom_range(8, 40);
      end
      return g;
   endfunction

   function automatic lpi_pkg::coord_type rand_coord();
      lpi_pkg::coord_type c;
      case ($urandom_range(0, 9)) inside
         0: begin
            c = C_MIN;
         end
         1: begin
            c = C_MAX;
         end
         2: begin
            c = '0;
         end
         3: begin
            c = -1;
         end
         [4:5]: begin
            c = $signed($urandom_range(0, 2000)) - 1000;
         end
         default: begin
            c = $urandom;
         end
      endcase
      return c;
   endfunction

   function automatic lpi_pkg::steps_type rand_steps();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         n = $urandom_range(0, 8);
      end else if (r < 90) begin
         n = $urandom_range(9, 30);
      end else begin
         n = $urandom_range(31, 63);
      end
      return n[lpi_pkg::STEPS_W-1:0];
   endfunction

   function automatic logic [lpi_pkg::REQ_DATA_W-1:0] pack_req(
      input lpi_pkg::coord_type sx, input lpi_pkg::coord_type sy,
      input lpi_pkg::coord_type sz, input lpi_pkg::coord_type ex,
      input lpi_pkg::coord_type ey, input lpi_pkg::coord_type ez,
      input lpi_pkg::steps_type n);
      logic [lpi_pkg::REQ_DATA_W-1:0] d;
      d = '0;
      d[0*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] = sx;
      d[1*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] = sy;
      d[2*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] = sz;
      d[3*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] = ex;
      d[4*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] = ey;
      d[5*lpi_pkg::COORD_W +: lpi_pkg::COORD_W] = ez;
      d[6*lpi_pkg::COORD_W +: lpi_pkg::STEPS_W] = n;
      return d;
   endfunction

   task automatic send_item(input logic [lpi_pkg::REQ_DATA_W-1:0] d);
      int g;
      g = gap_len(send_calm);
      if (g > 0) begin
         req_tvalid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_item(pack_req(0, 0, 0, 0, 0, 0, 6'd0));
      send_item(pack_req(1, 2, C_MIN, -5, 7, C_MIN, 6'd0));
      send_item(pack_req(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 6'd1));
      send_item(pack_req(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 6'd63));
      send_item(pack_req(C_MIN, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, 6'd63));
      send_item(pack_req(0, 0, 0, -7, 7, 7, 6'd2));
      send_item(pack_req(10, -10, 3, -10, 10, -3, 6'd3));
      send_item(pack_req(0, 0, 0, 1, -1, 1, 6'd63));
      send_item(pack_req(32'hffff_ffff, 32'h0, 32'hffff_ffff,
                         32'h0, 32'hffff_ffff, 32'h0, 6'd42));
      send_item(pack_req(32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                         32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 6'd21));
      send_item(pack_req(32'h0001_8000, -32'sh0002_4000, 32'h0000_8000,
                         -32'sh0001_8000, 32'h0003_0000, -32'sh0000_8000, 6'd4));
      send_item(pack_req(1234, -5678, 999, 1234, -5678, 999, 6'd5));
      send_item(pack_req(C_MIN, 0, C_MAX, C_MIN, 0, C_MAX, 6'd7));
      send_item(pack_req(rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), 6'd63));
      send_item(pack_req(-1, -1, -1, 0, 0, 0, 6'd6));

      repeat (RANDOM_ITEMS) begin
         if ($urandom_range(0, 15) == 0) begin
            send_calm = !send_calm;
         end
         send_item(pack_req(rand_coord(), rand_coord(), rand_coord(),
                            rand_coord(), rand_coord(), rand_coord(), rand_steps()));
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("line_point_interpolator: match");
      end else begin
         $display("line_point_interpolator: mismatch");
      end
      $finish;
   end

   // receiver, with one long hold-off so the block backs up
   initial begin
      int  got;
      int  g;
      bit  calm;
      got  = 0;
      calm = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 15) == 0) begin
            calm = !calm;
         end
         if (got == HOLD_AT) begin
            g = HOLD_CYCLES;
         end else begin
            g = gap_len(calm);
         end
         if (g > 0) begin
            rsp_tready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("line_point_interpolator: mismatch");
            $finish;
         end
      end
   end

endmodule
